>>> design/par_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// par_pkg: shared types and constants of the probe-and-adapt rate selector
// Holds the configuration register layout, register indexes and the widths
// of the shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
package par_pkg;

   // Bit-serial multiplier operand and product widths.
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Bit-serial divider widths.
   localparam int DIV_N_W = 56;
   localparam int DIV_D_W = 32;

   // Buffer fill is given in percent.
   localparam logic [DIV_D_W-1:0] PCT_DIVISOR = 32'd100;

   // Configuration port address width (eight 32-bit registers).
   localparam int CSR_ADDR_W = 5;

   // Register indexes.
   localparam logic [2:0] REG_SMOOTH_GAIN    = 3'd0;
   localparam logic [2:0] REG_BUFFER_GAIN    = 3'd1;
   localparam logic [2:0] REG_PROBE_GAIN     = 3'd2;
   localparam logic [2:0] REG_SAFETY_MARGIN  = 3'd3;
   localparam logic [2:0] REG_PROBE_STEP     = 3'd4;
   localparam logic [2:0] REG_MIN_BUFFER     = 3'd5;
   localparam logic [2:0] REG_SEGMENT_LENGTH = 3'd6;
   localparam logic [2:0] REG_LEVEL_COUNT    = 3'd7;

   // Register reset values.
   localparam logic [15:0] RST_SMOOTH_GAIN    = 16'd13107;
   localparam logic [15:0] RST_BUFFER_GAIN    = 16'd13107;
   localparam logic [15:0] RST_PROBE_GAIN     = 16'd9175;
   localparam logic [15:0] RST_SAFETY_MARGIN  = 16'd13107;
   localparam logic [23:0] RST_PROBE_STEP     = 24'd300000;
   localparam logic [12:0] RST_MIN_BUFFER     = 13'd2560;
   localparam logic [23:0] RST_SEGMENT_LENGTH = 24'd131072;
   localparam logic [4:0]  RST_LEVEL_COUNT    = 5'd1;

   // Configuration register file contents.
   typedef struct packed {
      logic [15:0] smooth_gain;
      logic [15:0] buffer_gain;
      logic [15:0] probe_gain;
      logic [15:0] safety_margin;
      logic [23:0] probe_step;
      logic [12:0] min_buffer;
      logic [23:0] segment_length;
      logic [4:0]  level_count;
   } par_cfg_type;

endpackage

`default_nettype wire

>>> design/par_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// par_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle, LSB first, and pulses done when the
// full product is available.
// ----------------------------------------------------------------------------
module par_mul
   import par_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [MUL_A_W-1:0] a,
   input  wire logic [MUL_B_W-1:0] b,
   output logic                    done,
   output logic [MUL_P_W-1:0]      product
);

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_P_W-1:0] p_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [MUL_A_W:0]   sum;

   // Add the multiplicand into the upper half when the current bit is set.
   always_comb begin
      sum = {1'b0, p_ff[MUL_P_W-1:MUL_B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
   end

   // Step counter and shift register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            p_ff    <= {{MUL_A_W{1'b0}}, b};
            cnt_ff  <= CNT_W'(MUL_B_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            p_ff   <= {sum, p_ff[MUL_B_W-1:1]};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

>>> design/par_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// par_div: bit-serial restoring divider
// Produces one quotient bit per cycle, MSB first, and pulses done once all
// DIV_N_W quotient bits are in. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module par_div
   import par_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] numer,
   input  wire logic [DIV_D_W-1:0] denom,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] n_ff;
   logic [DIV_D_W-1:0] r_ff;
   logic [DIV_D_W-1:0] d_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_D_W:0]   r_shift;
   logic [DIV_D_W:0]   r_diff;
   logic               fits;

   // Trial subtraction of one remainder step.
   always_comb begin
      r_shift = {r_ff, n_ff[DIV_N_W-1]};
      r_diff  = r_shift - {1'b0, d_ff};
      fits    = (r_shift >= {1'b0, d_ff});
   end

   // Quotient bits shift into the numerator register as it empties.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= numer;
            d_ff    <= denom;
            r_ff    <= '0;
            cnt_ff  <= CNT_W'(DIV_N_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            r_ff   <= fits ? r_diff[DIV_D_W-1:0] : r_shift[DIV_D_W-1:0];
            n_ff   <= {n_ff[DIV_N_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = n_ff;

endmodule

`default_nettype wire

>>> design/par_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// par_csr: configuration register file
// APB-style register port with eight 32-bit registers at word addresses.
// ----------------------------------------------------------------------------
module par_csr
   import par_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output par_cfg_type                cfg
);

   par_cfg_type cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smooth_gain    <= RST_SMOOTH_GAIN;
         cfg_ff.buffer_gain    <= RST_BUFFER_GAIN;
         cfg_ff.probe_gain     <= RST_PROBE_GAIN;
         cfg_ff.safety_margin  <= RST_SAFETY_MARGIN;
         cfg_ff.probe_step     <= RST_PROBE_STEP;
         cfg_ff.min_buffer     <= RST_MIN_BUFFER;
         cfg_ff.segment_length <= RST_SEGMENT_LENGTH;
         cfg_ff.level_count    <= RST_LEVEL_COUNT;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_SMOOTH_GAIN:    cfg_ff.smooth_gain    <= csr_pwdata[15:0];
            REG_BUFFER_GAIN:    cfg_ff.buffer_gain    <= csr_pwdata[15:0];
            REG_PROBE_GAIN:     cfg_ff.probe_gain     <= csr_pwdata[15:0];
            REG_SAFETY_MARGIN:  cfg_ff.safety_margin  <= csr_pwdata[15:0];
            REG_PROBE_STEP:     cfg_ff.probe_step     <= csr_pwdata[23:0];
            REG_MIN_BUFFER:     cfg_ff.min_buffer     <= csr_pwdata[12:0];
            REG_SEGMENT_LENGTH: cfg_ff.segment_length <= csr_pwdata[23:0];
            REG_LEVEL_COUNT:    cfg_ff.level_count    <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (reg_sel)
         REG_SMOOTH_GAIN:    csr_prdata = 32'(cfg_ff.smooth_gain);
         REG_BUFFER_GAIN:    csr_prdata = 32'(cfg_ff.buffer_gain);
         REG_PROBE_GAIN:     csr_prdata = 32'(cfg_ff.probe_gain);
         REG_SAFETY_MARGIN:  csr_prdata = 32'(cfg_ff.safety_margin);
         REG_PROBE_STEP:     csr_prdata = 32'(cfg_ff.probe_step);
         REG_MIN_BUFFER:     csr_prdata = 32'(cfg_ff.min_buffer);
         REG_SEGMENT_LENGTH: csr_prdata = 32'(cfg_ff.segment_length);
         REG_LEVEL_COUNT:    csr_prdata = 32'(cfg_ff.level_count);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/probe_adapt_rate_selector_top.sv
// Load transaction: accepted in the idle state, no result.
// Measure transaction: at most seven passes of the serial multiplier and two
// of the serial divider, and a table scan with a read and a compare state per
// entry, up to the effective level count.
// One transaction at a time; a finished result waits in the output register.
// Reset is synchronous: rate state and the register file return to defaults;
// the rate table holds no value until loaded.
`default_nettype none
// ----------------------------------------------------------------------------
// probe_adapt_rate_selector_top: probe-and-adapt bitrate controller
// Sequencer around a shared bit-serial multiplier and divider, the level
// table memory and the configuration register file.
// ----------------------------------------------------------------------------
module probe_adapt_rate_selector_top
   import par_pkg::*;
#(
   parameter int MAX_LEVELS         = 16,
   parameter int BUFFER_MAX_SECONDS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: level_index[3:0], level_rate[35:4], measured_rate[67:36],
   //        buffer_percent[74:68], download_duration[106:75]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [111:0]          req_tdata,
   // tuser: cmd[0]
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: chosen_level[3:0], chosen_rate[35:4], request_gap[67:36]
   output logic [71:0]                rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int LW    = $clog2(MAX_LEVELS);
   localparam int NW    = $clog2(MAX_LEVELS + 1);
   localparam int BMS_W = $clog2(BUFFER_MAX_SECONDS + 1);
   localparam int PP_W  = 7 + BMS_W;
   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROBE_P, ST_PROBE_M, ST_SMOOTH, ST_SMOOTH_P, ST_SMOOTH_M,
      ST_MARGIN, ST_THRESH, ST_SCAN_RD, ST_SCAN_CMP, ST_CHOOSE, ST_NUM,
      ST_QUOT, ST_BSEC, ST_BTERM, ST_FINAL
   } state_type;

   // Apply a signed change to a rate, clamped to the 32-bit range.
   function automatic logic [31:0] apply_change(input logic [31:0] base,
                                                input logic        neg,
                                                input logic [48:0] mag);
      logic [32:0] sum;
      begin
         sum = {1'b0, base} + {1'b0, mag[31:0]};
         if (mag[48:32] != '0) begin
            apply_change = neg ? '0 : U32_MAX;
         end else if (neg) begin
            apply_change = (mag[31:0] >= base) ? '0 : base - mag[31:0];
         end else begin
            apply_change = sum[32] ? U32_MAX : sum[31:0];
         end
      end
   endfunction

   par_cfg_type cfg;

   state_type          state_ff;
   logic [31:0]        target_ff, smooth_ff, gap_time_ff, cur_rate_ff;
   logic [LW-1:0]      cur_level_ff;
   logic [31:0]        bps_ff, dl_ff;
   logic [6:0]         pct_ff;
   logic [31:0]        thr_dn_ff, thr_up_ff;
   logic [NW-1:0]      scan_idx_ff;
   logic               dn_found_ff, up_found_ff;
   logic [LW-1:0]      lvl_dn_ff, lvl_up_ff;
   logic [31:0]        r_dn_ff, r_up_ff;
   logic [DIV_N_W-1:0] quot_ff;
   logic               berr_neg_ff;
   logic [31:0]        res_gap_ff;
   logic               rsp_valid_ff;
   logic [3:0]         rsp_level_ff;
   logic [31:0]        rsp_rate_ff, rsp_gap_ff;
   logic               mul_start_ff, div_start_ff;
   logic [MUL_A_W-1:0] mul_a_ff;
   logic [MUL_B_W-1:0] mul_b_ff;
   logic [DIV_N_W-1:0] div_n_ff;
   logic [DIV_D_W-1:0] div_d_ff;

   logic [31:0]        rate_mem [MAX_LEVELS];
   logic [31:0]        rd_ff;

   logic               mul_done, div_done;
   logic [MUL_P_W-1:0] mul_prod;
   logic [DIV_N_W-1:0] div_quo;

   logic               req_fire;
   logic               req_cmd;
   logic [3:0]         req_level_index;
   logic [31:0]        req_level_rate, req_measured_rate, req_download_duration;
   logic [6:0]         req_buffer_percent;
   logic [NW-1:0]      n_eff;
   logic [33:0]        w34;
   logic [33:0]        probe_d, smooth_d, thr_dn_s, thr_up_s;
   logic               probe_lt, probe_neg, smooth_neg;
   logic [32:0]        probe_m, smooth_m, margin_e;
   logic               dn_hit, up_hit, scan_last;
   logic [31:0]        choose_rate;
   logic [PP_W-1:0]    pct_prod;
   logic [32:0]        berr;
   logic [31:0]        berr_mag;
   logic [57:0]        gap_s;
   logic [31:0]        gap_clamped;

   // Register file.
   par_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Shared serial arithmetic units.
   par_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   par_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .numer    (div_n_ff),
      .denom    (div_d_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Input field unpacking.
   assign req_cmd               = req_tuser[0];
   assign req_level_index       = req_tdata[3:0];
   assign req_level_rate        = req_tdata[35:4];
   assign req_measured_rate     = req_tdata[67:36];
   assign req_buffer_percent    = req_tdata[74:68];
   assign req_download_duration = req_tdata[106:75];
   assign req_tready            = (state_ff == ST_IDLE);
   assign req_fire              = req_tvalid && req_tready;

   // Level table: written by load transactions, read one entry per cycle.
   always_ff @(posedge clock) begin
      if (req_fire && !req_cmd && (32'(req_level_index) < MAX_LEVELS)) begin
         rate_mem[LW'(req_level_index)] <= req_level_rate;
      end
      rd_ff <= rate_mem[scan_idx_ff[LW-1:0]];
   end

   // Datapath terms evaluated by the sequencer.
   always_comb begin
      if (cfg.level_count == '0) begin
         n_eff = NW'(1);
      end else if (32'(cfg.level_count) > MAX_LEVELS) begin
         n_eff = NW'(MAX_LEVELS);
      end else begin
         n_eff = NW'(cfg.level_count);
      end

      w34 = 34'(cfg.probe_step);

      // Probe change toward the measured rate; an increase is capped by the probe step.
      probe_d   = {2'b00, bps_ff} - {2'b00, target_ff};
      probe_lt  = $signed(probe_d) < $signed(w34);
      probe_neg = probe_lt && probe_d[33];
      if (!probe_lt) begin
         probe_m = w34[32:0];
      end else if (probe_d[33]) begin
         probe_m = 33'(-probe_d);
      end else begin
         probe_m = probe_d[32:0];
      end

      // Smoothing error.
      smooth_d   = {2'b00, target_ff} - {2'b00, smooth_ff};
      smooth_neg = smooth_d[33];
      smooth_m   = smooth_neg ? 33'(-smooth_d) : smooth_d[32:0];

      // Thresholds: margin term is rounded up.
      margin_e = {1'b0, mul_prod[47:16]} + 33'(mul_prod[15:0] != '0);
      thr_dn_s = {2'b00, smooth_ff} - w34;
      thr_up_s = thr_dn_s - {1'b0, margin_e};

      // Table scan.
      dn_hit    = !dn_found_ff && (rd_ff > thr_dn_ff);
      up_hit    = !up_found_ff && (rd_ff > thr_up_ff);
      scan_last = ({1'b0, scan_idx_ff} + (NW + 1)'(1)) >= {1'b0, n_eff};

      // Dead-zone level choice.
      if (cur_rate_ff < r_up_ff) begin
         choose_rate = r_up_ff;
      end else if (cur_rate_ff > r_dn_ff) begin
         choose_rate = r_dn_ff;
      end else begin
         choose_rate = cur_rate_ff;
      end

      // Buffer error in Q16.16 seconds.
      pct_prod = PP_W'(pct_ff) * PP_W'(BUFFER_MAX_SECONDS);
      berr     = {1'b0, div_quo[31:0]} - 33'({cfg.min_buffer, 8'h00});
      berr_mag = berr[32] ? 32'(-berr) : berr[31:0];

      // Rate term plus buffer term, clamped.
      if (berr_neg_ff) begin
         gap_s = {2'b00, quot_ff} - {26'd0, mul_prod[47:16]};
      end else begin
         gap_s = {2'b00, quot_ff} + {26'd0, mul_prod[47:16]};
      end
      if (gap_s[57]) begin
         gap_clamped = '0;
      end else if (gap_s[56:32] != '0) begin
         gap_clamped = U32_MAX;
      end else begin
         gap_clamped = gap_s[31:0];
      end
   end

   // Sequencer and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         smooth_ff    <= '0;
         gap_time_ff  <= '0;
         cur_rate_ff  <= '0;
         cur_level_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         // The final state reloads the output register itself.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINAL)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_cmd) begin
                  bps_ff <= req_measured_rate;
                  pct_ff <= req_buffer_percent;
                  dl_ff  <= req_download_duration;
                  if (target_ff == '0) begin
                     target_ff <= req_measured_rate;
                     state_ff  <= ST_SMOOTH;
                  end else begin
                     mul_a_ff     <= MUL_A_W'(gap_time_ff);
                     mul_b_ff     <= MUL_B_W'(cfg.probe_gain);
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_PROBE_P;
                  end
               end
            end
            ST_PROBE_P: begin
               if (mul_done) begin
                  mul_a_ff     <= mul_prod[MUL_A_W-1:0];
                  mul_b_ff     <= probe_m;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_PROBE_M;
               end
            end
            ST_PROBE_M: begin
               if (mul_done) begin
                  target_ff <= apply_change(target_ff, probe_neg, mul_prod[80:32]);
                  state_ff  <= ST_SMOOTH;
               end
            end
            ST_SMOOTH: begin
               if (gap_time_ff == '0) begin
                  smooth_ff <= target_ff;
                  state_ff  <= ST_MARGIN;
               end else begin
                  mul_a_ff     <= MUL_A_W'(gap_time_ff);
                  mul_b_ff     <= MUL_B_W'(cfg.smooth_gain);
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SMOOTH_P;
               end
            end
            ST_SMOOTH_P: begin
               if (mul_done) begin
                  mul_a_ff     <= mul_prod[MUL_A_W-1:0];
                  mul_b_ff     <= smooth_m;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SMOOTH_M;
               end
            end
            ST_SMOOTH_M: begin
               if (mul_done) begin
                  smooth_ff <= apply_change(smooth_ff, smooth_neg, mul_prod[80:32]);
                  state_ff  <= ST_MARGIN;
               end
            end
            ST_MARGIN: begin
               mul_a_ff     <= MUL_A_W'(smooth_ff);
               mul_b_ff     <= MUL_B_W'(cfg.safety_margin);
               mul_start_ff <= 1'b1;
               state_ff     <= ST_THRESH;
            end
            ST_THRESH: begin
               if (mul_done) begin
                  thr_dn_ff   <= thr_dn_s[33] ? '0 : thr_dn_s[31:0];
                  thr_up_ff   <= thr_up_s[33] ? '0 : thr_up_s[31:0];
                  scan_idx_ff <= '0;
                  dn_found_ff <= 1'b0;
                  up_found_ff <= 1'b0;
                  state_ff    <= ST_SCAN_RD;
               end
            end
            ST_SCAN_RD: begin
               state_ff <= ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               // A level stays tentative until a larger entry ends its run.
               if (!dn_found_ff) begin
                  if (dn_hit) begin
                     dn_found_ff <= 1'b1;
                     if (scan_idx_ff == '0) begin
                        lvl_dn_ff <= '0;
                        r_dn_ff   <= rd_ff;
                     end
                  end else begin
                     lvl_dn_ff <= scan_idx_ff[LW-1:0];
                     r_dn_ff   <= rd_ff;
                  end
               end
               if (!up_found_ff) begin
                  if (up_hit) begin
                     up_found_ff <= 1'b1;
                     if (scan_idx_ff == '0) begin
                        lvl_up_ff <= '0;
                        r_up_ff   <= rd_ff;
                     end
                  end else begin
                     lvl_up_ff <= scan_idx_ff[LW-1:0];
                     r_up_ff   <= rd_ff;
                  end
               end
               if (scan_last || ((dn_found_ff || dn_hit) && (up_found_ff || up_hit))) begin
                  state_ff <= ST_CHOOSE;
               end else begin
                  scan_idx_ff <= scan_idx_ff + NW'(1);
                  state_ff    <= ST_SCAN_RD;
               end
            end
            ST_CHOOSE: begin
               if (cur_rate_ff < r_up_ff) begin
                  cur_level_ff <= lvl_up_ff;
               end else if (cur_rate_ff > r_dn_ff) begin
                  cur_level_ff <= lvl_dn_ff;
               end
               cur_rate_ff  <= choose_rate;
               mul_a_ff     <= MUL_A_W'(choose_rate);
               mul_b_ff     <= MUL_B_W'(cfg.segment_length);
               mul_start_ff <= 1'b1;
               state_ff     <= ST_NUM;
            end
            ST_NUM: begin
               if (mul_done) begin
                  if (smooth_ff == '0) begin
                     res_gap_ff <= (mul_prod == '0) ? '0 : U32_MAX;
                     state_ff   <= ST_FINAL;
                  end else begin
                     div_n_ff     <= mul_prod[DIV_N_W-1:0];
                     div_d_ff     <= smooth_ff;
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_QUOT;
                  end
               end
            end
            ST_QUOT: begin
               if (div_done) begin
                  quot_ff      <= div_quo;
                  div_n_ff     <= DIV_N_W'({pct_prod, 16'h0000});
                  div_d_ff     <= PCT_DIVISOR;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_BSEC;
               end
            end
            ST_BSEC: begin
               if (div_done) begin
                  berr_neg_ff  <= berr[32];
                  mul_a_ff     <= MUL_A_W'(berr_mag);
                  mul_b_ff     <= MUL_B_W'(cfg.buffer_gain);
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_BTERM;
               end
            end
            ST_BTERM: begin
               if (mul_done) begin
                  res_gap_ff <= gap_clamped;
                  state_ff   <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= 4'(cur_level_ff);
                  rsp_rate_ff  <= cur_rate_ff;
                  rsp_gap_ff   <= (dl_ff > res_gap_ff) ? dl_ff : res_gap_ff;
                  gap_time_ff  <= (dl_ff > res_gap_ff) ? dl_ff : res_gap_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_gap_ff, rsp_rate_ff, rsp_level_ff};

`ifndef SYNTHESIS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_start_ff && div_start_ff))
      else $error("multiplier and divider started together");

   a_rsp_rate_current: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_rate_ff == cur_rate_ff))
      else $error("result rate differs from current rate");

   a_gap_not_below_download: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_gap_ff >= dl_ff))
      else $error("request gap below download time");

   a_gap_state_tracks_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (gap_time_ff == rsp_gap_ff))
      else $error("stored gap time differs from returned gap");
`endif

endmodule

`default_nettype wire

>>> dv/probe_adapt_rate_selector_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// probe_adapt_rate_selector_top_tb: self-checking bench of the rate selector
// Drives table loads and measure transactions on the request stream and
// writes the register file between phases. A scoreboard class keeps its own
// copy of the rate state and predicts every result. Both stream sides idle at
// random, and one long result stall fills the block up.
// ----------------------------------------------------------------------------
module probe_adapt_rate_selector_top_tb
   import par_pkg::*;
;

   localparam bit CMD_LOAD    = 1'b0;
   localparam bit CMD_MEASURE = 1'b1;
   localparam int LEVELS      = 16;
   localparam int BUF_SECONDS = 20;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int HOLD_CYCLES = 3000;
   localparam longint unsigned MAX32 = 64'hFFFF_FFFF;
   localparam longint unsigned BIG   = 64'h2_0000_0000;

   typedef struct {
      bit        cmd;
      bit [3:0]  idx;
      bit [31:0] lrate;
      bit [31:0] mrate;
      bit [6:0]  pct;
      bit [31:0] dl;
   } req_item_type;

   typedef struct {
      bit [3:0]  level;
      bit [31:0] rate;
      bit [31:0] gap;
   } rate_choice_type;

   // Scoreboard: predicts choices from accepted transactions and checks them.
   class rate_scoreboard;
      bit [31:0] table_q[LEVELS];
      bit [31:0] target, smoothed, gap_time, cur_rate;
      bit [3:0]  cur_level;
      bit [15:0] alpha, beta, kgain, eps;
      bit [23:0] wstep, seglen;
      bit [12:0] minbuf;
      bit [4:0]  nlev;
      rate_choice_type pending[$];
      int errors;

      function void reset_state();
         foreach (table_q[i]) table_q[i] = 0;
         target = 0; smoothed = 0; gap_time = 0; cur_rate = 0; cur_level = 0;
         alpha = RST_SMOOTH_GAIN; beta = RST_BUFFER_GAIN; kgain = RST_PROBE_GAIN;
         eps = RST_SAFETY_MARGIN; wstep = RST_PROBE_STEP; minbuf = RST_MIN_BUFFER;
         seglen = RST_SEGMENT_LENGTH; nlev = RST_LEVEL_COUNT;
         errors = 0;
      endfunction

      function void set_reg(bit [2:0] idx, bit [31:0] v);
         case (idx)
            REG_SMOOTH_GAIN:    alpha  = v[15:0];
            REG_BUFFER_GAIN:    beta   = v[15:0];
            REG_PROBE_GAIN:     kgain  = v[15:0];
            REG_SAFETY_MARGIN:  eps    = v[15:0];
            REG_PROBE_STEP:     wstep  = v[23:0];
            REG_MIN_BUFFER:     minbuf = v[12:0];
            REG_SEGMENT_LENGTH: seglen = v[23:0];
            default:            nlev   = v[4:0];
         endcase
      endfunction

      // (p*m)>>32 with saturation at the big-adjustment bound.
      function longint unsigned mul_q32(longint unsigned p, longint unsigned m);
         logic [127:0] pr;
         longint unsigned r;
         pr = 128'(p) * 128'(m);
         if (pr[127:64] != 0) return BIG;
         r = pr[95:32];
         return (r > BIG) ? BIG : r;
      endfunction

      function bit [31:0] nudge(bit [31:0] base, bit neg, longint unsigned mag);
         longint unsigned sum;
         if (neg) return (mag >= base) ? 32'd0 : 32'(base - mag);
         sum = base + mag;
         return (sum > MAX32) ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function bit [3:0] scan_level(bit [31:0] thr, int n);
         int i;
         for (i = 0; i < n; i++)
            if (table_q[i] > thr) break;
         return (i > 0) ? 4'(i - 1) : 4'd0;
      endfunction

      function void note_input(req_item_type it);
         longint w, d, thr_dn, thr_up, bsec, berr, bterm, gap;
         longint unsigned p, e, num, mag;
         int n;
         bit [3:0] lv_up, lv_dn;
         rate_choice_type c;
         if (it.cmd == CMD_LOAD) begin
            table_q[it.idx] = it.lrate;
            return;
         end
         w = longint'(wstep);
         // Additive probing of the target rate.
         if (target == 0) target = it.mrate;
         else begin
            p = longint'(kgain) * longint'(gap_time);
            d = longint'(it.mrate) - longint'(target);
            if (d < w) target = nudge(target, d < 0, mul_q32(p, (d < 0) ? -d : d));
            else target = nudge(target, 1'b0, mul_q32(p, w));
         end
         // Smoothing scaled by the previous request gap.
         if (gap_time == 0) smoothed = target;
         else begin
            p = longint'(alpha) * longint'(gap_time);
            d = longint'(target) - longint'(smoothed);
            smoothed = nudge(smoothed, d < 0, mul_q32(p, (d < 0) ? -d : d));
         end
         // Dead-zone level choice.
         n = (nlev == 0) ? 1 : ((nlev > LEVELS) ? LEVELS : int'(nlev));
         e = (longint'(eps) * longint'(smoothed) + 65535) >> 16;
         thr_dn = longint'(smoothed) - w;
         thr_up = thr_dn - longint'(e);
         if (thr_dn < 0) thr_dn = 0;
         if (thr_up < 0) thr_up = 0;
         lv_dn = scan_level(32'(thr_dn), n);
         lv_up = scan_level(32'(thr_up), n);
         if (cur_rate < table_q[lv_up]) begin
            cur_rate = table_q[lv_up]; cur_level = lv_up;
         end else if (cur_rate > table_q[lv_dn]) begin
            cur_rate = table_q[lv_dn]; cur_level = lv_dn;
         end
         // Next request gap.
         num = longint'(cur_rate) * longint'(seglen);
         if (smoothed == 0) gap = (num == 0) ? 0 : longint'(MAX32);
         else begin
            bsec = (longint'(it.pct) * BUF_SECONDS * 65536) / 100;
            berr = bsec - (longint'(minbuf) <<< 8);
            mag = ((berr < 0) ? -berr : berr) * longint'(beta) >> 16;
            bterm = (berr < 0) ? -longint'(mag) : longint'(mag);
            gap = longint'(num / smoothed) + bterm;
         end
         gap_time = (gap < 0) ? 32'd0 : ((gap > longint'(MAX32)) ? 32'hFFFF_FFFF : 32'(gap));
         if (it.dl > gap_time) gap_time = it.dl;
         c.level = cur_level; c.rate = cur_rate; c.gap = gap_time;
         pending = {pending, c};
      endfunction

      function void check_result(bit [71:0] data);
         rate_choice_type c;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", data);
            return;
         end
         c = pending.pop_front();
         if (data[3:0] != c.level || data[35:4] != c.rate || data[67:36] != c.gap) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: level %0d/%0d rate %0d/%0d gap %0d/%0d (exp/act)",
                        c.level, data[3:0], c.rate, data[35:4], c.gap, data[67:36]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rate_scoreboard choices = new();
   int req_idle_pct = 25;
   int rsp_idle_pct = 69;
   bit hold_rsp = 0;
   int cycles = 0;

   probe_adapt_rate_selector_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("probe_adapt_rate_selector_top_tb: errors");
         $finish;
      end
   end

   // Result side: check accepted transactions, then pick the next ready.
   initial begin : rsp_side
      int held;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) choices.check_result(rsp_tdata);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            held++;
            if (held >= HOLD_CYCLES) begin
               hold_rsp = 0;
               held = 0;
            end
         end else
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(req_item_type it);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= {5'd0, it.dl, it.pct, it.mrate, it.lrate, it.idx};
      do @(posedge clock); while (!req_tready);
      choices.note_input(it);
   endtask

   task automatic load_entry(bit [3:0] idx, bit [31:0] r);
      req_item_type it;
      it.cmd = CMD_LOAD; it.idx = idx; it.lrate = r;
      it.mrate = $urandom(); it.pct = 7'($urandom()); it.dl = $urandom();
      send_item(it);
   endtask

   task automatic measure(bit [31:0] r, bit [6:0] pct, bit [31:0] dl);
      req_item_type it;
      it.cmd = CMD_MEASURE; it.idx = 4'($urandom()); it.lrate = $urandom();
      it.mrate = r; it.pct = pct; it.dl = dl;
      send_item(it);
   endtask

   // Fill the whole table with an ascending ladder of random spacing.
   task automatic load_ladder(int shift);
      bit [31:0] r;
      r = $urandom_range(0, 1 << 20);
      for (int i = 0; i < LEVELS; i++) begin
         load_entry(4'(i), r);
         r += ($urandom() >> shift) + 1;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (choices.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Setup and access phases, then idle before the next write.
   task automatic csr_write(bit [2:0] idx, bit [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00}); csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      choices.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Register settings per phase: random, maximum, minimum, reset values with a level count of 16.
   task automatic configure(int phase);
      bit [31:0] v[8];
      case (phase % 4)
         1: v = '{32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFF_FFFF, 5120, 32'hFF_FFFF, 31};
         2: v = '{0, 0, 0, 0, 0, 0, 1, 0};
         3: v = '{RST_SMOOTH_GAIN, RST_BUFFER_GAIN, RST_PROBE_GAIN, RST_SAFETY_MARGIN,
                  RST_PROBE_STEP, RST_MIN_BUFFER, RST_SEGMENT_LENGTH, 16};
         default: v = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12),
                        $urandom_range(0, 5120), $urandom_range(1, 24'hFF_FFFF),
                        $urandom_range(1, 16)};
      endcase
      for (int i = 0; i < 8; i++) csr_write(3'(i), v[i]);
   endtask

   // Mostly rates close to a table entry, sometimes full range or zero; some items reload the table.
   task automatic random_item();
      bit [31:0] r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) load_entry(4'($urandom()), $urandom());
      else if (pick < 9) load_ladder($urandom_range(4, 8));
      else begin
         if (pick < 70)
            r = choices.table_q[$urandom_range(0, LEVELS - 1)] + $urandom_range(0, 1 << 22)
                - (1 << 21);
         else if (pick < 92) r = $urandom();
         else r = 0;
         measure(r, ($urandom_range(0, 9) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100)),
                 ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 19));
      end
   endtask

   initial begin : stimulus
      choices.reset_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full table with extreme entries, then extreme measures.
      load_entry(4'd0, 32'd0);
      for (int i = 1; i < LEVELS - 1; i++) load_entry(4'(i), 32'(i) * 32'd250000);
      load_entry(4'd15, 32'hFFFF_FFFF);
      measure(32'd0, 7'd0, 32'd0);
      measure(32'd0, 7'd100, 32'd0);
      measure(32'd1_000_000, 7'd50, 32'd0);
      measure(32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF);
      measure(32'd0, 7'd0, 32'd65536);
      measure(32'd2_000_000, 7'd100, 32'd0);
      wait_drained();
      csr_write(REG_LEVEL_COUNT, 32'd0);
      measure(32'd3_000_000, 7'd30, 32'd0);
      wait_drained();
      csr_write(REG_LEVEL_COUNT, 32'd17);
      measure(32'd500_000, 7'd127, 32'd131072);
      measure(32'hFFFF_FFFF, 7'd1, 32'd0);

      // Random phases with changing settings and idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         req_idle_pct = (phase < 3) ? 25 : ((phase < 6) ? 69 : 0);
         rsp_idle_pct = (phase < 3) ? 69 : ((phase < 6) ? 25 : 0);
         configure(phase);
         if (phase == 0) load_ladder(5);
         for (int k = 0; k < 85; k++) begin
            if (phase == 1 && k == 10) hold_rsp = 1;
            if (phase == 4 && k == 60) wait_drained();
            random_item();
         end
      end

      wait_drained();
      repeat (500) @(posedge clock);
      if (choices.pending.size() != 0) choices.errors++;
      if (choices.errors == 0) $display("probe_adapt_rate_selector_top_tb: clean");
      else $display("probe_adapt_rate_selector_top_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
